// ----- src/integer_matrix_multiply_assert.svh -----
// ----------------------------------------------------------------------------
// integer matrix multiply assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef INTEGER_MATRIX_MULTIPLY_ASSERT_SVH
`define INTEGER_MATRIX_MULTIPLY_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, off during reset
`define IMM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// next-cycle implication, off during reset
`define IMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`else

`define IMM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define IMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/imm_pkg.sv -----
// ----------------------------------------------------------------------------
// imm_pkg
// shared sizes, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package imm_pkg;

	localparam int DIM       = 16;
	localparam int IDX_W     = $clog2(DIM);
	localparam int MEM_DEPTH = DIM * DIM;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int DATA_W    = 32;

	typedef enum logic [1:0] {
		ACT_LOAD_A  = 2'd0,
		ACT_LOAD_B  = 2'd1,
		ACT_COMPUTE = 2'd2
	} act_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic              we_a;
		logic              we_b;
		logic [ADDR_W-1:0] wr_addr;
		logic              issue;
		logic              first;
		logic              last_term;
		logic [ADDR_W-1:0] rd_addr_a;
		logic [ADDR_W-1:0] rd_addr_b;
		logic              push;
		logic [IDX_W-1:0]  out_row;
		logic [IDX_W-1:0]  out_col;
		logic              out_last;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sum_done;
		logic out_free;
	} dp_status_t;

endpackage

// ----- src/imm_ctrl.sv -----
// ----------------------------------------------------------------------------
// imm_ctrl
// sequencer: accepts items, steps row/column/term counters, issues mac terms
// ----------------------------------------------------------------------------
module imm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic [3:0]         row,
	input  logic [3:0]         col,
	input  imm_pkg::dp_status_t status,
	output imm_pkg::ctrl_cmd_t  cmd
);
	import imm_pkg::*;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] row_q, row_d;
	logic [IDX_W-1:0] col_q, col_d;
	logic [IDX_W-1:0] k_q, k_d;
	logic             in_xfer;
	logic             row_ok;
	logic             col_ok;
	logic             col_end;
	logic             k_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			col_q   <= col_d;
			k_q     <= k_d;
		end
	end

	assign in_xfer = in_valid && in_ready;
	assign row_ok  = 32'(row) < DIM;
	assign col_ok  = 32'(col) < DIM;
	assign col_end = col_q == IDX_W'(DIM - 1);
	assign k_end   = k_q == IDX_W'(DIM - 1);

	always_comb begin
		state_d  = state_q;
		row_d    = row_q;
		col_d    = col_q;
		k_d      = k_q;
		in_ready = 1'b0;

		cmd           = '0;
		cmd.wr_addr   = ADDR_W'(32'(row) * DIM + 32'(col));
		cmd.rd_addr_a = ADDR_W'(32'(row_q) * DIM + 32'(k_q));
		cmd.rd_addr_b = ADDR_W'(32'(k_q) * DIM + 32'(col_q));
		cmd.first     = k_q == '0;
		cmd.last_term = k_end;
		cmd.out_row   = row_q;
		cmd.out_col   = col_q;
		cmd.out_last  = col_end;

		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				// out-of-range loads and the unused action code are dropped
				cmd.we_a = in_xfer && action == ACT_LOAD_A && row_ok && col_ok;
				cmd.we_b = in_xfer && action == ACT_LOAD_B && row_ok && col_ok;
				if (in_xfer && action == ACT_COMPUTE && row_ok) begin
					row_d   = IDX_W'(row);
					col_d   = '0;
					k_d     = '0;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				if (k_end) begin
					k_d     = '0;
					state_d = ST_WAIT;
				end else begin
					k_d = k_q + IDX_W'(1);
				end
			end
			ST_WAIT: begin
				if (status.sum_done && status.out_free) begin
					cmd.push = 1'b1;
					if (col_end) begin
						state_d = ST_IDLE;
					end else begin
						col_d   = col_q + IDX_W'(1);
						state_d = ST_RUN;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- src/imm_datapath.sv -----
// ----------------------------------------------------------------------------
// imm_datapath
// element stores, pipelined multiply-accumulate and the result register
// ----------------------------------------------------------------------------
module imm_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  imm_pkg::ctrl_cmd_t  cmd,
	input  logic signed [31:0]  element,
	output imm_pkg::dp_status_t status,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [3:0]          out_row,
	output logic [3:0]          out_col,
	output logic signed [31:0]  product,
	output logic                last
);
	import imm_pkg::*;

	logic [DATA_W-1:0] mem_a [MEM_DEPTH];
	logic [DATA_W-1:0] mem_b [MEM_DEPTH];

	logic [DATA_W-1:0] a_s1, b_s1;
	logic              issue_s1, first_s1, last_s1;
	logic [DATA_W-1:0] prod_s2;
	logic              issue_s2, first_s2, last_s2;
	logic [DATA_W-1:0] acc_q;
	logic              done_q;
	logic              out_valid_q;
	logic [3:0]        out_row_q, out_col_q;
	logic [DATA_W-1:0] product_q;
	logic              last_q;

	// stores: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (cmd.we_a) begin
			mem_a[cmd.wr_addr] <= element;
		end
		if (cmd.we_b) begin
			mem_b[cmd.wr_addr] <= element;
		end
		a_s1 <= mem_a[cmd.rd_addr_a];
		b_s1 <= mem_b[cmd.rd_addr_b];
	end

	// low 32 bits of the product are the same for signed and unsigned
	always_ff @(posedge clk) begin
		prod_s2 <= a_s1 * b_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			issue_s2 <= 1'b0;
			first_s2 <= 1'b0;
			last_s2  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			issue_s1 <= cmd.issue;
			first_s1 <= cmd.first;
			last_s1  <= cmd.last_term;
			issue_s2 <= issue_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			if (issue_s2 && last_s2) begin
				done_q <= 1'b1;
			end else if (cmd.push) begin
				done_q <= 1'b0;
			end
		end
	end

	// accumulate with wraparound, restart on the first term of a column
	always_ff @(posedge clk) begin
		if (issue_s2) begin
			acc_q <= first_s2 ? prod_s2 : acc_q + prod_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			product_q <= acc_q;
			out_row_q <= 4'(cmd.out_row);
			out_col_q <= 4'(cmd.out_col);
			last_q    <= cmd.out_last;
		end
	end

	assign status.sum_done = done_q;
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign product   = product_q;
	assign last      = last_q;

endmodule

// ----- src/integer_matrix_multiply.sv -----
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// square signed matrix product, one row of C per compute item
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// items     in         in_valid / in_ready    action, row, col, element
// results   out        out_valid / out_ready  out_row, out_col, product, last
//
// a load is written in the cycle it is taken; a compute item is served by the
// single multiply-accumulate unit: DIM terms per column pass through the store
// read, multiply and accumulate stages, after the idle state in which the item
// is taken
// a stalled result holds the next column at its final push; no item is taken
// while a row is being computed
// reset is asynchronous and clears control state only; the stores hold
// nothing defined until loaded
// ----------------------------------------------------------------------------
`include "integer_matrix_multiply_assert.svh"

module integer_matrix_multiply (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic [3:0]         row,
	input  logic [3:0]         col,
	input  logic signed [31:0] element,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         out_row,
	output logic [3:0]         out_col,
	output logic signed [31:0] product,
	output logic               last
);
	import imm_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	imm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.row      (row),
		.col      (col),
		.status   (status),
		.cmd      (cmd)
	);

	imm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.element   (element),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_row   (out_row),
		.out_col   (out_col),
		.product   (product),
		.last      (last)
	);

	// a result is never pushed over one that has not been transferred
	`IMM_ASSERT_IMPLY(a_push_free, clk, arst_n, cmd.push, status.out_free)
	// no mac term is issued while items are being taken
	`IMM_ASSERT_IMPLY(a_issue_busy, clk, arst_n, cmd.issue, !in_ready)
	// store writes only happen on an item transfer
	`IMM_ASSERT_IMPLY(a_write_xfer, clk, arst_n, cmd.we_a || cmd.we_b, in_valid && in_ready)
	// the final column of a row frees the input side
	`IMM_ASSERT_NEXT(a_row_end, clk, arst_n, cmd.push && cmd.out_last, in_ready)

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: integer matrix multiply testbench
// loads both element stores, computes rows of C = A x B and checks every
// product against a scoreboard model with 32-bit wraparound; covers extreme
// elements, the unused action code, random handshake gaps and a long result
// stall that backs up the item channel
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import imm_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int ROW_CYCLES  = DIM * (DIM + 3);
	localparam int RANDOM_ITEMS = 60;

	typedef struct packed {
		logic [3:0]  r;
		logic [3:0]  c;
		logic [31:0] value;
		logic        is_last;
	} product_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic [1:0]         action    = ACT_UNUSED;
	logic [3:0]         row       = '0;
	logic [3:0]         col       = '0;
	logic signed [31:0] element   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [3:0]         out_row;
	logic [3:0]         out_col;
	logic signed [31:0] product;
	logic               last;

	// scoreboard copy of both stores, row-major
	logic [31:0] mat_a [DIM][DIM];
	logic [31:0] mat_b [DIM][DIM];
	product_t    pending_products[$];
	// rows of A with every column loaded, the only rows that may be computed
	bit          a_row_full [DIM];

	int  err_count    = 0;
	int  cycle_count  = 0;
	int  hold_cycles  = 0;
	bit  send_steady  = 1'b0;
	bit  take_steady  = 1'b0;

	integer_matrix_multiply u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.row       (row),
		.col       (col),
		.element   (element),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_row   (out_row),
		.out_col   (out_col),
		.product   (product),
		.last      (last)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic flag_error(input string msg);
		$display("error @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic logic [31:0] row_dot(input int r, input int c);
		logic [31:0] acc;
		int k;
		acc = '0;
		for (k = 0; k < DIM; k++)
			acc = acc + mat_a[r][k] * mat_b[k][c];
		return acc;
	endfunction

	function automatic void apply_item(input logic [1:0] act, input logic [3:0] r,
			input logic [3:0] c, input logic [31:0] e);
		product_t p;
		int j;
		case (act)
			ACT_LOAD_A: if (r < DIM && c < DIM) mat_a[r][c] = e;
			ACT_LOAD_B: if (r < DIM && c < DIM) mat_b[r][c] = e;
			ACT_COMPUTE: begin
				if (r < DIM) begin
					for (j = 0; j < DIM; j++) begin
						p.r       = r;
						p.c       = j[3:0];
						p.value   = row_dot(r, j);
						p.is_last = (j == DIM - 1);
						pending_products.push_back(p);
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] pick_element();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'h0;
			4: return 32'h1;
			5, 6: return 32'($signed($urandom_range(0, 200)) - 100);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [3:0] pick_full_row();
		logic [3:0] r;
		do r = 4'($urandom); while (!a_row_full[r]);
		return r;
	endfunction

	// called just after a rising edge; valid stays up when the next item follows at once
	task automatic send_item(input logic [1:0] act, input logic [3:0] r,
			input logic [3:0] c, input logic [31:0] e);
		int gap;
		gap = send_steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		row      <= r;
		col      <= c;
		element  <= e;
		do @(posedge clk); while (!in_ready);
		apply_item(act, r, c, e);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_products.size() != 0);
	endtask

	// result side: random stall per transfer, or a long hold when requested
	initial begin
		int stall;
		product_t want;
		@(posedge arst_n);
		forever begin
			stall = take_steady ? 0 : $urandom_range(0, 7);
			if (hold_cycles > 0) begin
				stall = hold_cycles;
				hold_cycles = 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			if (pending_products.size() == 0) begin
				flag_error($sformatf("unexpected result row %0d col %0d", out_row, out_col));
			end else begin
				want = pending_products.pop_front();
				if (out_row !== want.r)
					flag_error($sformatf("row %0d col %0d: out_row %0d", want.r, want.c, out_row));
				if (out_col !== want.c)
					flag_error($sformatf("row %0d col %0d: out_col %0d", want.r, want.c, out_col));
				if (product !== want.value)
					flag_error($sformatf("row %0d col %0d: product %h, want %h",
						want.r, want.c, product, want.value));
				if (last !== want.is_last)
					flag_error($sformatf("row %0d col %0d: last %b", want.r, want.c, last));
			end
		end
	end

	// unused action code before anything is loaded: no write, no result
	task automatic test_unused_action();
		int n;
		for (n = 0; n < 4; n++)
			send_item(ACT_UNUSED, 4'($urandom), 4'($urandom), $urandom);
		send_item(ACT_UNUSED, 4'hf, 4'hf, 32'hffff_ffff);
		wait_drained();
	endtask

	// all of B and a few whole rows of A, extremes on chosen rows and columns
	task automatic test_fill_stores();
		int r;
		int c;
		logic [31:0] va;
		logic [31:0] vb;
		for (r = 0; r < DIM; r++) begin
			send_steady = (r % 4 == 0);
			for (c = 0; c < DIM; c++) begin
				vb = (c == 0) ? 32'h8000_0000 : (c == DIM - 1) ? 32'h7fff_ffff :
					(c == 1) ? 32'h1 : pick_element();
				send_item(ACT_LOAD_B, r[3:0], c[3:0], vb);
				if (r inside {0, 1, 3, DIM - 1}) begin
					va = (r == 0) ? 32'h8000_0000 : (r == DIM - 1) ? 32'h7fff_ffff :
						(r == 1) ? 32'hffff_ffff : pick_element();
					send_item(ACT_LOAD_A, r[3:0], c[3:0], va);
				end
			end
			if (r inside {0, 1, 3, DIM - 1})
				a_row_full[r] = 1'b1;
		end
		send_steady = 1'b0;
		wait_drained();
	endtask

	task automatic test_directed_rows();
		send_item(ACT_COMPUTE, 4'd0, 4'd0, 32'h0);
		send_item(ACT_COMPUTE, 4'd15, 4'hf, 32'hffff_ffff);
		send_item(ACT_COMPUTE, 4'd1, 4'd0, 32'h0);
		send_item(ACT_UNUSED, 4'd1, 4'd0, 32'h7fff_ffff);
		send_item(ACT_COMPUTE, 4'd1, 4'd0, 32'h0);
		send_item(ACT_LOAD_A, 4'd3, 4'd0, 32'h7fff_ffff);
		send_item(ACT_LOAD_B, 4'd0, 4'd7, 32'h8000_0000);
		send_item(ACT_COMPUTE, 4'd3, 4'd3, 32'h0);
		send_item(ACT_LOAD_A, 4'd15, 4'd15, 32'h0);
		send_item(ACT_LOAD_B, 4'd15, 4'd15, 32'h0);
		send_item(ACT_COMPUTE, 4'd15, 4'd0, 32'h0);
		send_item(ACT_LOAD_A, 4'd15, 4'd15, 32'h7fff_ffff);
		send_item(ACT_LOAD_B, 4'd15, 4'd15, 32'h7fff_ffff);
		send_item(ACT_COMPUTE, 4'd15, 4'd0, 32'h0);
		wait_drained();
	endtask

	// results held back for a long stretch while items keep being offered
	task automatic test_result_hold();
		send_steady = 1'b1;
		take_steady = 1'b1;
		hold_cycles = 3 * ROW_CYCLES;
		send_item(ACT_COMPUTE, 4'd3, 4'd0, 32'h0);
		send_item(ACT_COMPUTE, 4'd0, 4'd0, 32'h0);
		send_item(ACT_LOAD_A, 4'd3, 4'd5, pick_element());
		send_item(ACT_COMPUTE, 4'd3, 4'd0, 32'h0);
		send_item(ACT_LOAD_B, 4'd5, 4'd9, pick_element());
		send_item(ACT_COMPUTE, 4'd15, 4'd0, 32'h0);
		send_steady = 1'b0;
		take_steady = 1'b0;
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int sent;
		int n;
		int k;
		logic [1:0] act;
		logic [3:0] r;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			send_steady = ($urandom_range(0, 3) == 0);
			take_steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 7) begin
				// reload part of one row of A, a few entries of B, then compute a full row
				r = 4'($urandom);
				n = $urandom_range(0, 16);
				for (k = 0; k < n; k++)
					send_item(ACT_LOAD_A, r, (n == 16) ? k[3:0] : 4'($urandom),
						pick_element());
				if (n == 16)
					a_row_full[r] = 1'b1;
				sent += n;
				n = $urandom_range(0, 4);
				for (k = 0; k < n; k++)
					send_item(ACT_LOAD_B, 4'($urandom), 4'($urandom), pick_element());
				sent += n;
				if (!a_row_full[r])
					r = pick_full_row();
				send_item(ACT_COMPUTE, r, 4'($urandom), $urandom);
				sent++;
			end else begin
				act = 2'($urandom);
				r = (act == ACT_COMPUTE) ? pick_full_row() : 4'($urandom);
				send_item(act, r, 4'($urandom), pick_element());
				sent++;
			end
		end
		send_steady = 1'b0;
		take_steady = 1'b0;
		wait_drained();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unused_action();
		test_fill_stores();
		test_directed_rows();
		test_result_hold();
		test_random_traffic();
		// anything arriving now has no expectation and is flagged by the checker
		repeat (2 * ROW_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
